// ===== design/fsps_pkg.sv =====
package fsps_pkg;

    localparam int NUM_MOTORS   = 4;
    localparam int PERIOD_W     = 10;
    localparam int COIL_W       = 4;
    localparam int PHASE_W      = 2;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd50;
    localparam logic [COIL_W-1:0]   COIL_IDLE    = 4'hF;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    localparam logic [2:0] MOVE_FWD   = 3'd0;
    localparam logic [2:0] MOVE_BACK  = 3'd1;
    localparam logic [2:0] MOVE_LEFT  = 3'd2;
    localparam logic [2:0] MOVE_RIGHT = 3'd3;
    localparam logic [2:0] MOVE_CW    = 3'd4;
    localparam logic [2:0] MOVE_CCW   = 3'd5;

    typedef struct packed {
        logic tick;
        logic set_dir;
        logic stop;
        logic running;
    } lane_ctrl_t;

    typedef struct packed {
        logic                    valid;
        logic [NUM_MOTORS-1:0]   fwd;
    } dir_set_t;

    function automatic dir_set_t move_dirs(input logic [2:0] code);
        dir_set_t d;
        d.valid = 1'b1;
        case (code)
            MOVE_FWD:   d.fwd = 4'hF;
            MOVE_BACK:  d.fwd = 4'h0;
            MOVE_LEFT:  d.fwd = 4'h6;
            MOVE_RIGHT: d.fwd = 4'h9;
            MOVE_CW:    d.fwd = 4'hA;
            MOVE_CCW:   d.fwd = 4'h5;
            default:
            begin
                d.valid = 1'b0;
                d.fwd   = 4'h0;
            end
        endcase
        return d;
    endfunction

    // odd motors walk 3,9,C,6 and even motors 3,6,C,9
    function automatic logic [COIL_W-1:0] coil_pattern(input logic even_order,
                                                       input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] p;
        case (phase)
            2'd0: p = 4'h3;
            2'd1: p = even_order ? 4'h6 : 4'h9;
            2'd2: p = 4'hC;
            2'd3: p = even_order ? 4'h9 : 4'h6;
            default: p = COIL_IDLE;
        endcase
        return p;
    endfunction

endpackage

// ===== design/fsps_motor.sv =====
module fsps_motor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          even_order,
    input  logic                          cfg_wr,
    input  logic [fsps_pkg::PERIOD_W-1:0] cfg_data,
    input  fsps_pkg::lane_ctrl_t          ctrl,
    input  logic                          dir_fwd,
    output logic [fsps_pkg::COIL_W-1:0]   coil_next,
    output logic                          stepped
);
    import fsps_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] counter_reg, counter_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                fwd_reg, fwd_next;
    logic [COIL_W-1:0]   coil_reg;

    always_comb
    begin
        stepped      = ctrl.tick && (counter_reg == '0) && ctrl.running;
        counter_next = counter_reg;
        phase_next   = phase_reg;
        fwd_next     = ctrl.set_dir ? dir_fwd : fwd_reg;
        coil_next    = coil_reg;
        if (ctrl.tick)
        begin
            if (counter_reg != '0)
            begin
                counter_next = counter_reg - 1'b1;
            end
            else if (ctrl.running)
            begin
                counter_next = period_reg;
                coil_next    = coil_pattern(even_order, phase_reg);
                phase_next   = fwd_reg ? phase_reg + 1'b1 : phase_reg - 1'b1;
            end
        end
        if (ctrl.stop)
        begin
            coil_next = COIL_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RESET;
            counter_reg <= '0;
            phase_reg   <= '0;
            fwd_reg     <= 1'b1;
            coil_reg    <= COIL_IDLE;
        end
        else
        begin
            if (cfg_wr)
            begin
                period_reg <= cfg_data;
            end
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
            fwd_reg     <= fwd_next;
            coil_reg    <= coil_next;
        end
    end

endmodule

// ===== design/four_stepper_phase_sequencer.sv =====
// four_stepper_phase_sequencer
// Full-step coil sequencer for four unipolar steppers.
// Input channel (in_valid / in_stall): kind selects a time tick, a move
// command (move_code sets the four direction bits) or run control (run_on).
// Output channel (out_valid / out_stall): one beat per input beat carrying
// the four coil nibbles, the mask of motors that stepped and the run flag.
// Configuration: cfg_we writes cfg_data into the period register chosen by
// cfg_index (motor 1..4 as index 0..3); write only while no beat is in flight.
// Pipeline: an accepted beat is registered in the input register; its result
// is registered in the result register when it commits, and out_valid rises with it.
// Throughput: one beat per cycle while no result is stalled; all motor state updates as a
// beat moves from the input register into the result register.
// Stall: while out_stall holds a result, the input register holds its beat
// and in_stall rises once that register is full; nothing is dropped.
// Reset: motors stopped, motor coil registers 0xF (output coil registers are not reset),
// phases and counters zero, all directions forward, every period 50.
module four_stepper_phase_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       kind,
    input  logic [2:0]                       move_code,
    input  logic                             run_on,
    input  logic                             cfg_we,
    input  logic [fsps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fsps_pkg::PERIOD_W-1:0]    cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fsps_pkg::COIL_W-1:0]      coils_motor1,
    output logic [fsps_pkg::COIL_W-1:0]      coils_motor2,
    output logic [fsps_pkg::COIL_W-1:0]      coils_motor3,
    output logic [fsps_pkg::COIL_W-1:0]      coils_motor4,
    output logic [fsps_pkg::NUM_MOTORS-1:0]  stepped_mask,
    output logic                             running
);
    import fsps_pkg::*;

    logic                  s1_valid_reg;
    logic [1:0]            s1_kind_reg;
    logic [2:0]            s1_code_reg;
    logic                  s1_run_reg;
    logic                  out_valid_reg;
    logic                  running_reg, running_next;
    logic                  advance_out;
    logic                  commit;
    lane_ctrl_t            ctrl;
    dir_set_t              dirs;
    logic [COIL_W-1:0]     coil_next [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] step_vec;
    logic [COIL_W-1:0]     coils_reg [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] mask_reg;
    logic                  running_out_reg;

    assign advance_out = !out_valid_reg || !out_stall;
    assign in_stall    = s1_valid_reg && !advance_out;
    assign commit      = s1_valid_reg && advance_out;
    assign dirs        = move_dirs(s1_code_reg);

    always_comb
    begin
        running_next = running_reg;
        if (commit && (s1_kind_reg == KIND_RUN))
        begin
            running_next = s1_run_reg;
        end
        ctrl.tick    = commit && (s1_kind_reg == KIND_TICK);
        ctrl.set_dir = commit && (s1_kind_reg == KIND_MOVE) && dirs.valid;
        ctrl.stop    = commit && (s1_kind_reg == KIND_RUN) && !s1_run_reg;
        ctrl.running = running_reg;
    end

    for (genvar m = 0; m < NUM_MOTORS; m++)
    begin : g_motor
        fsps_motor u_motor (
            .clk        (clk),
            .rst_n      (rst_n),
            .even_order (m[0]),
            .cfg_wr     (cfg_we && (cfg_index == m[CFG_INDEX_W-1:0])),
            .cfg_data   (cfg_data),
            .ctrl       (ctrl),
            .dir_fwd    (dirs.fwd[m]),
            .coil_next  (coil_next[m]),
            .stepped    (step_vec[m])
        );

        always_ff @(posedge clk)
        begin
            if (commit)
            begin
                coils_reg[m] <= running_next ? coil_next[m] : COIL_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            running_reg <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_kind_reg <= kind;
            s1_code_reg <= move_code;
            s1_run_reg  <= run_on;
        end
        if (commit)
        begin
            mask_reg        <= step_vec;
            running_out_reg <= running_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign coils_motor1 = coils_reg[0];
    assign coils_motor2 = coils_reg[1];
    assign coils_motor3 = coils_reg[2];
    assign coils_motor4 = coils_reg[3];
    assign stepped_mask = mask_reg;
    assign running      = running_out_reg;

endmodule

// ===== dv/coil_sequence_checker.sv =====
`timescale 1ns / 100ps

module coil_sequence_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [1:0]                       kind,
    input  logic [2:0]                       move_code,
    input  logic                             run_on,
    input  logic                             cfg_we,
    input  logic [fsps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fsps_pkg::PERIOD_W-1:0]    cfg_data,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [fsps_pkg::COIL_W-1:0]      coils_motor1,
    input  logic [fsps_pkg::COIL_W-1:0]      coils_motor2,
    input  logic [fsps_pkg::COIL_W-1:0]      coils_motor3,
    input  logic [fsps_pkg::COIL_W-1:0]      coils_motor4,
    input  logic [fsps_pkg::NUM_MOTORS-1:0]  stepped_mask,
    input  logic                             running,
    output int                               mismatches,
    output int                               beats_owed
);
    import fsps_pkg::*;

    // coil nibbles for phases 0..3, phase 0 in the low nibble
    localparam logic [4*COIL_W-1:0] ODD_WALK  = 16'h6C93;
    localparam logic [4*COIL_W-1:0] EVEN_WALK = 16'h9C63;

    typedef struct packed {
        logic [NUM_MOTORS-1:0][COIL_W-1:0] coils;
        logic [NUM_MOTORS-1:0]             stepped;
        logic                              running;
    } coil_snapshot_t;

    logic [PERIOD_W-1:0]   period_reg [NUM_MOTORS];
    logic [PERIOD_W-1:0]   countdown  [NUM_MOTORS];
    logic [PHASE_W-1:0]    phase      [NUM_MOTORS];
    logic [COIL_W-1:0]     coil_latch [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] heading_fwd;
    logic                  motors_on;

    coil_snapshot_t snapshots_due [$];

    function automatic logic [NUM_MOTORS-1:0] heading_for(input logic [2:0] code,
                                                          input logic [NUM_MOTORS-1:0] now);
        case (code)
            MOVE_FWD:   return 4'hF;
            MOVE_BACK:  return 4'h0;
            MOVE_LEFT:  return 4'h6;
            MOVE_RIGHT: return 4'h9;
            MOVE_CW:    return 4'hA;
            MOVE_CCW:   return 4'h5;
            default:    return now;
        endcase
    endfunction

    task automatic predict_beat(input logic [1:0] k, input logic [2:0] code,
                                input logic run_req);
        coil_snapshot_t snap;
        snap.stepped = '0;
        case (k)
            KIND_TICK:
            begin
                for (int m = 0; m < NUM_MOTORS; m++)
                begin
                    if (countdown[m] != '0)
                    begin
                        countdown[m] = countdown[m] - 1'b1;
                    end
                    else if (motors_on)
                    begin
                        coil_latch[m] = (m % 2 == 0) ? ODD_WALK[phase[m]*COIL_W +: COIL_W]
                                                     : EVEN_WALK[phase[m]*COIL_W +: COIL_W];
                        phase[m] = heading_fwd[m] ? phase[m] + 2'd1 : phase[m] - 2'd1;
                        countdown[m] = period_reg[m];
                        snap.stepped[m] = 1'b1;
                    end
                end
            end
            KIND_MOVE:
            begin
                heading_fwd = heading_for(code, heading_fwd);
            end
            KIND_RUN:
            begin
                motors_on = run_req;
                if (!run_req)
                begin
                    for (int m = 0; m < NUM_MOTORS; m++)
                    begin
                        coil_latch[m] = COIL_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            snap.coils[m] = motors_on ? coil_latch[m] : COIL_IDLE;
        end
        snap.running = motors_on;
        snapshots_due.push_back(snap);
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        mismatches++;
        $error("%s: expected %h, got %h", field, want, got);
    endtask

    task automatic check_beat();
        coil_snapshot_t                    want;
        logic [NUM_MOTORS-1:0][COIL_W-1:0] seen;
        if (snapshots_due.size() == 0)
        begin
            mismatches++;
            $error("result beat with no expectation waiting");
            return;
        end
        want = snapshots_due.pop_front();
        seen = {coils_motor4, coils_motor3, coils_motor2, coils_motor1};
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            if (seen[m] !== want.coils[m])
            begin
                note_mismatch($sformatf("coils_motor%0d", m + 1), 8'(want.coils[m]),
                              8'(seen[m]));
            end
        end
        if (stepped_mask !== want.stepped)
        begin
            note_mismatch("stepped_mask", 8'(want.stepped), 8'(stepped_mask));
        end
        if (running !== want.running)
        begin
            note_mismatch("running", 8'(want.running), 8'(running));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                period_reg[m] = PERIOD_RESET;
                countdown[m]  = '0;
                phase[m]      = '0;
                coil_latch[m] = COIL_IDLE;
            end
            heading_fwd = '1;
            motors_on   = 1'b0;
            snapshots_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_beat();
            end
            if (cfg_we)
            begin
                period_reg[cfg_index] = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                predict_beat(kind, move_code, run_on);
            end
        end
        beats_owed = snapshots_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import fsps_pkg::*;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam logic [2:0] MOVE_KEEP_A = 3'd6;
    localparam logic [2:0] MOVE_KEEP_B = 3'd7;
    localparam int         PHASES      = 6;
    localparam int         PHASE_BEATS = 235;
    localparam int         IDLE_LIMIT  = 2000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [1:0]               kind      = KIND_TICK;
    logic [2:0]               move_code = MOVE_FWD;
    logic                     run_on    = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [PERIOD_W-1:0]      cfg_data  = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b1;
    logic [COIL_W-1:0]        coils_motor1;
    logic [COIL_W-1:0]        coils_motor2;
    logic [COIL_W-1:0]        coils_motor3;
    logic [COIL_W-1:0]        coils_motor4;
    logic [NUM_MOTORS-1:0]    stepped_mask;
    logic                     running;
    int                       mismatches;
    int                       beats_owed;
    logic                     quiet_tx  = 1'b0;
    logic                     quiet_rx  = 1'b0;

    always #5 clk = ~clk;

    four_stepper_phase_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .move_code    (move_code),
        .run_on       (run_on),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coils_motor1 (coils_motor1),
        .coils_motor2 (coils_motor2),
        .coils_motor3 (coils_motor3),
        .coils_motor4 (coils_motor4),
        .stepped_mask (stepped_mask),
        .running      (running)
    );

    coil_sequence_checker coil_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .move_code    (move_code),
        .run_on       (run_on),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coils_motor1 (coils_motor1),
        .coils_motor2 (coils_motor2),
        .coils_motor3 (coils_motor3),
        .coils_motor4 (coils_motor4),
        .stepped_mask (stepped_mask),
        .running      (running),
        .mismatches   (mismatches),
        .beats_owed   (beats_owed)
    );

    task automatic send_beat(input logic [1:0] k, input logic [2:0] code, input logic run_req);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        move_code <= code;
        run_on    <= run_req;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random_beat();
        int         pick;
        logic [2:0] code;
        logic       run_req;
        pick    = $urandom_range(0, 99);
        code    = 3'($urandom_range(0, 7));
        run_req = 1'($urandom_range(0, 1));
        if (pick < 70)
            send_beat(KIND_TICK, code, run_req);
        else if (pick < 84)
            send_beat(KIND_MOVE, code, run_req);
        else if (pick < 90)
            send_beat(KIND_RUN, code, 1'b1);
        else if (pick < 95)
            send_beat(KIND_RUN, code, run_req);
        else
            send_beat(KIND_SPARE, code, run_req);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (beats_owed != 0);
        @(posedge clk);
    endtask

    task automatic load_periods(input logic [NUM_MOTORS-1:0][PERIOD_W-1:0] periods);
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_W'(m);
            cfg_data  <= periods[m];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // result side: random stall before each beat
    always
    begin
        int hold;
        hold = quiet_rx ? 0 : $urandom_range(0, 9);
        repeat (hold)
        begin
            out_stall <= 1'b1;
            @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!(out_valid && !out_stall));
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [NUM_MOTORS-1:0][PERIOD_W-1:0] periods;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset periods: stopped, started, then stopped again
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_SPARE, 3'($urandom), 1'($urandom));
        send_beat(KIND_RUN, 3'($urandom), 1'b1);
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_MOVE, MOVE_KEEP_A, 1'($urandom));
        send_beat(KIND_MOVE, MOVE_KEEP_B, 1'($urandom));
        send_beat(KIND_RUN, 3'($urandom), 1'b0);

        // zero periods, with every move code between ticks while running
        hold_until_drained();
        load_periods('0);
        send_beat(KIND_RUN, 3'($urandom), 1'b1);
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_MOVE, MOVE_LEFT, 1'($urandom));
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_MOVE, MOVE_RIGHT, 1'($urandom));
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_MOVE, MOVE_CW, 1'($urandom));
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_MOVE, MOVE_CCW, 1'($urandom));
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_MOVE, MOVE_BACK, 1'($urandom));
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_MOVE, MOVE_FWD, 1'($urandom));
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));
        send_beat(KIND_RUN, 3'($urandom), 1'b0);
        send_beat(KIND_TICK, 3'($urandom), 1'($urandom));

        for (int p = 0; p < PHASES; p++)
        begin
            hold_until_drained();
            for (int m = 0; m < NUM_MOTORS; m++)
            begin
                case (p)
                    0:       periods[m] = PERIOD_W'(m);
                    1:       periods[m] = (m == 0) ? '1 : PERIOD_W'(m * 2);
                    2:       periods[m] = PERIOD_W'($urandom_range(0, 7));
                    3:       periods[m] = '1;
                    4:       periods[m] = PERIOD_W'($urandom_range(0, 3));
                    default: periods[m] = PERIOD_W'($urandom_range(0, 1023));
                endcase
            end
            load_periods(periods);
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                if (i % 40 == 0)
                begin
                    quiet_tx = ($urandom_range(0, 3) == 0);
                    quiet_rx = ($urandom_range(0, 3) == 0);
                end
                send_random_beat();
            end
        end

        hold_until_drained();
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && beats_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
